### rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants, types and helpers for the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CFG_W = 13;
	localparam int WIDTH_W = 11;
	localparam int HEIGHT_W = 13;
	localparam int LANES = 3;

	localparam logic [0:0] REG_WIDTH = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef logic [23:0] pixel_t;

	// 3x3 window of one channel, [col][row], col 0 left, row 0 top
	typedef logic [2:0][2:0][7:0] win_t;

	typedef struct packed {
		logic row_end;
		logic frame_end;
	} tag_t;

	typedef enum logic [2:0] {S_IDLE, S_READ, S_W0, S_W1, S_PUSH0, S_PUSH1} st_t;

	function automatic logic [WIDTH_W-1:0] limit_width(input logic [WIDTH_W-1:0] v);
		if (v == '0) return WIDTH_W'(1);
		if (v > WIDTH_W'(MAX_WIDTH)) return WIDTH_W'(MAX_WIDTH);
		return v;
	endfunction

	function automatic logic [HEIGHT_W-1:0] limit_height(input logic [HEIGHT_W-1:0] v);
		return (v == '0) ? HEIGHT_W'(1) : v;
	endfunction
endpackage

### rtl/sem_stream_if.sv
// ----------------------------------------------------------------------------
// sem_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface sem_stream_if #(parameter int W = 24);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/sem_lane.sv
// ----------------------------------------------------------------------------
// sem_lane
// One channel lane: Sobel gradients, squared sum, rounded clamped sqrt.
// Stages: gradients, squares, a 12-step bit-serial root, then round and clamp.
// ----------------------------------------------------------------------------
module sem_lane (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sem_pkg::win_t win,
	output logic done,
	output logic [7:0] mag
);
	import sem_pkg::*;

	logic signed [10:0] gx_q, gy_q;
	logic [20:0] n_q;
	logic [11:0] s_q;
	logic [11:0] bit_q;
	logic [1:0] phase_q;
	logic [11:0] t;
	logic [23:0] tt;
	logic [11:0] s_f;
	logic [24:0] ss;

	function automatic logic signed [10:0] px(input logic [7:0] v);
		return signed'({3'b000, v});
	endfunction

	always_comb begin
		t = s_q | bit_q;
		tt = t * t;
		ss = {13'b0, s_q} * {13'b0, s_q} + {13'b0, s_q};
		s_f = (25'(n_q) > ss) ? s_q + 12'd1 : s_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (phase_q)
				2'd0: if (start) phase_q <= 2'd1;
				2'd1: phase_q <= 2'd2;
				2'd2: if (bit_q == 12'd1) phase_q <= 2'd3;
				default: begin
					phase_q <= 2'd0;
					done <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			2'd0: if (start) begin
				gx_q <= (px(win[2][0]) + (px(win[2][1]) <<< 1) + px(win[2][2]))
					- (px(win[0][0]) + (px(win[0][1]) <<< 1) + px(win[0][2]));
				gy_q <= (px(win[0][2]) + (px(win[1][2]) <<< 1) + px(win[2][2]))
					- (px(win[0][0]) + (px(win[1][0]) <<< 1) + px(win[2][0]));
			end
			2'd1: begin
				n_q <= 21'(gx_q * gx_q) + 21'(gy_q * gy_q);
				s_q <= '0;
				bit_q <= 12'd2048;
			end
			2'd2: begin
				if (24'(n_q) >= tt) s_q <= t;
				bit_q <= bit_q >> 1;
			end
			default: mag <= (s_f > 12'd255) ? 8'd255 : s_f[7:0];
		endcase
	end
endmodule

### rtl/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel edge magnitude on RGB pixels, three channel lanes.
//
// channel  dir  payload
// pix_in   in   red, green, blue
// edge_out out  edge_red, edge_green, edge_blue, row_end, frame_end
// cfg      in   cfg_we, cfg_index, cfg_data (0 width, 1 height)
//
// An item is accepted in S_IDLE and its line-store reads land in the next.
// Each window it completes runs through the three lanes (gradients,
// squares, 12 root steps, round). The next item is not accepted until
// the item's windows have been taken into the output register; output
// stalls delay that. Reset clears counters and window; line stores are
// masked by row count. A stalled output holds one result while the next item
// is taken.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb (
	input  logic clk,
	input  logic arst_n,
	sem_stream_if.sink pix_in,
	sem_stream_if.source edge_out,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [sem_pkg::CFG_W-1:0] cfg_data
);
	import sem_pkg::*;

	pixel_t store_a [MAX_WIDTH];
	pixel_t store_b [MAX_WIDTH];
	pixel_t rd_a_q, rd_b_q, px_q;
	pixel_t wc_q [6];
	pixel_t cur0, cur1, cur2;
	logic [WIDTH_W-1:0] width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic flush_q;
	logic e0_q, e1_q;
	st_t st_q;
	pixel_t l_c [3], m_c [3], r_c [3];
	win_t win [LANES];
	logic [LANES-1:0] ldone;
	logic [7:0] lmag [LANES];
	logic lstart;
	tag_t tag_q;
	logic [25:0] ob_q;
	logic ob_v_q;
	logic last;
	logic hold_q;
	logic take;

	assign pix_in.ready = (st_q == S_IDLE);
	assign last = (WIDTH_W'(col_q) + WIDTH_W'(1) == width_q);
	assign cur0 = (row_q >= 13'd2) ? rd_b_q : '0;
	assign cur1 = (row_q >= 13'd1) ? rd_a_q : '0;
	assign cur2 = flush_q ? '0 : px_q;

	// lane results wait in hold_q until the output register is free
	assign take = (st_q == S_W0 || st_q == S_W1) && ((&ldone) || hold_q) && !ob_v_q;

	always_ff @(posedge clk) begin
		if (pix_in.valid && pix_in.ready) begin
			rd_a_q <= store_a[col_q];
			rd_b_q <= store_b[col_q];
			px_q <= pix_in.data;
		end
		if (st_q == S_READ) begin
			store_a[col_q] <= px_q;
			store_b[col_q] <= rd_a_q;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			l_c[k] = '0; m_c[k] = '0; r_c[k] = '0;
		end
		if (st_q == S_W0 || (st_q == S_READ && e0_q)) begin
			for (int k = 0; k < 3; k++) begin
				l_c[k] = (col_q >= COL_W'(2)) ? wc_q[3+k] : '0;
				m_c[k] = wc_q[k];
			end
			r_c[0] = cur0; r_c[1] = cur1; r_c[2] = cur2;
		end else begin
			for (int k = 0; k < 3; k++) l_c[k] = (col_q >= COL_W'(1)) ? wc_q[k] : '0;
			m_c[0] = cur0; m_c[1] = cur1; m_c[2] = cur2;
		end
		for (int ln = 0; ln < LANES; ln++)
			for (int k = 0; k < 3; k++) begin
				win[ln][0][k] = l_c[k][8*(2-ln) +: 8];
				win[ln][1][k] = m_c[k][8*(2-ln) +: 8];
				win[ln][2][k] = r_c[k][8*(2-ln) +: 8];
			end
	end

	assign lstart = (st_q == S_READ) && (e0_q || e1_q)
		|| (st_q == S_PUSH0 && e1_q && !ob_v_q);

	genvar g;
	generate
		for (g = 0; g < LANES; g++) begin : g_lane
			sem_lane u_lane (.clk(clk), .arst_n(arst_n), .start(lstart),
				.win(win[g]), .done(ldone[g]), .mag(lmag[g]));
		end
	endgenerate

	assign edge_out.valid = ob_v_q;
	assign edge_out.data = ob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			width_q <= WIDTH_W'(MAX_WIDTH);
			height_q <= HEIGHT_W'(1024);
			col_q <= '0;
			row_q <= '0;
			ob_v_q <= 1'b0;
			ob_q <= '0;
			tag_q <= '0;
			hold_q <= 1'b0;
			flush_q <= 1'b0;
			e0_q <= 1'b0;
			e1_q <= 1'b0;
			for (int k = 0; k < 6; k++) wc_q[k] <= '0;
		end else begin
			hold_q <= ((&ldone) || hold_q) && !take;
			if (edge_out.valid && edge_out.ready) ob_v_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH: width_q <= limit_width(cfg_data[WIDTH_W-1:0]);
					default: height_q <= limit_height(cfg_data);
				endcase
				col_q <= '0;
				row_q <= '0;
				for (int k = 0; k < 6; k++) wc_q[k] <= '0;
			end
			unique case (st_q)
				S_IDLE: if (pix_in.valid) begin
					st_q <= S_READ;
					flush_q <= (row_q >= height_q);
					e0_q <= (row_q >= 13'd1) && (col_q >= COL_W'(1));
					e1_q <= (row_q >= 13'd1)
						&& (WIDTH_W'(col_q) + WIDTH_W'(1) == width_q);
				end
				S_READ: begin
					if (e0_q) begin
						st_q <= S_W0;
						tag_q <= '{row_end: 1'b0, frame_end: 1'b0};
					end else if (e1_q) begin
						st_q <= S_W1;
						tag_q <= '{row_end: 1'b1, frame_end: flush_q};
					end else st_q <= S_PUSH1;
				end
				S_W0: if (take) begin
					ob_q <= {lmag[0], lmag[1], lmag[2], tag_q.row_end, tag_q.frame_end};
					ob_v_q <= 1'b1;
					st_q <= S_PUSH0;
				end
				S_PUSH0: if (!e1_q) st_q <= S_PUSH1;
					else if (!ob_v_q) begin
						st_q <= S_W1;
						tag_q <= '{row_end: 1'b1, frame_end: flush_q};
					end
				S_W1: if (take) begin
					ob_q <= {lmag[0], lmag[1], lmag[2], tag_q.row_end, tag_q.frame_end};
					ob_v_q <= 1'b1;
					st_q <= S_PUSH1;
				end
				default: begin
					st_q <= S_IDLE;
					wc_q[3] <= wc_q[0]; wc_q[4] <= wc_q[1]; wc_q[5] <= wc_q[2];
					wc_q[0] <= cur0; wc_q[1] <= cur1; wc_q[2] <= cur2;
					if (last) begin
						col_q <= '0;
						row_q <= (row_q >= height_q) ? '0 : row_q + 13'd1;
					end else col_q <= col_q + COL_W'(1);
				end
			endcase
		end
	end
endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB Sobel edge magnitude block. Raster frames
// of random size and content go in through a bursty sender while the output
// side stalls on a shifting pattern. Every accepted pixel updates a local
// line-store and window model that predicts the edge results, which are
// compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
	import sem_pkg::*;

	typedef struct packed {
		logic [7:0] mag_r;
		logic [7:0] mag_g;
		logic [7:0] mag_b;
		logic row_end;
		logic frame_end;
	} edge_res_t;

	typedef pixel_t column_t [3];

	typedef enum logic [1:0] {ROW_SET_W, ROW_SET_H, ROW_PIX} row_kind_t;

	typedef struct {
		row_kind_t kind;
		int unsigned value;
		pixel_t px;
		bit pinned;
		edge_res_t pin;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	sem_stream_if #(.W(24)) pix_ch ();
	sem_stream_if #(.W(26)) mag_ch ();

	sobel_edge_magnitude_rgb DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(pix_ch.sink),
		.edge_out(mag_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// edge model state
	pixel_t prev_row [MAX_WIDTH];
	pixel_t prev_row2 [MAX_WIDTH];
	pixel_t win [6];
	int unsigned col_cnt, row_cnt, width_cfg, height_cfg;

	edge_res_t expected_edges [$];
	int unsigned fail_cnt;
	int unsigned items_sent;
	bit pin_armed;
	edge_res_t pin_val;
	int unsigned burst_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("sobel_edge_magnitude_rgb verification failed");
		$finish;
	end

	function automatic logic [7:0] rounded_root(input int unsigned n);
		int unsigned s;
		int unsigned t;
		s = 0;
		for (int b = 11; b >= 0; b--) begin
			t = s | (1 << b);
			if (t * t <= n) s = t;
		end
		if (n > s * s + s) s++;
		return (s > 255) ? 8'd255 : s[7:0];
	endfunction

	function automatic logic [7:0] lane_mag(input column_t l, input column_t m,
			input column_t r, input int sh);
		int gx, gy;
		int tl, ml, bl, tc, bc, tr, mr, br;
		tl = (l[0] >> sh) & 8'hFF; ml = (l[1] >> sh) & 8'hFF; bl = (l[2] >> sh) & 8'hFF;
		tc = (m[0] >> sh) & 8'hFF; bc = (m[2] >> sh) & 8'hFF;
		tr = (r[0] >> sh) & 8'hFF; mr = (r[1] >> sh) & 8'hFF; br = (r[2] >> sh) & 8'hFF;
		gx = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
		gy = (bl + 2 * bc + br) - (tl + 2 * tc + tr);
		return rounded_root(gx * gx + gy * gy);
	endfunction

	function automatic edge_res_t window_edge(input column_t l, input column_t m,
			input column_t r, input int unsigned col, input bit flush);
		edge_res_t e;
		e.mag_r = lane_mag(l, m, r, 16);
		e.mag_g = lane_mag(l, m, r, 8);
		e.mag_b = lane_mag(l, m, r, 0);
		e.row_end = (col + 1 == width_cfg);
		e.frame_end = e.row_end && flush;
		return e;
	endfunction

	function automatic void predict_edges(input pixel_t px);
		column_t cur, left, mid, blank;
		edge_res_t e;
		bit flush;
		int unsigned c, r;
		int produced;
		c = col_cnt;
		r = row_cnt;
		flush = (r >= height_cfg);
		blank = '{default: '0};
		produced = 0;
		cur[0] = (r >= 2) ? prev_row2[c] : '0;
		cur[1] = (r >= 1) ? prev_row[c] : '0;
		cur[2] = flush ? '0 : px;
		mid = '{win[0], win[1], win[2]};
		left = (c >= 2) ? column_t'{win[3], win[4], win[5]} : blank;
		if (r >= 1) begin
			if (c >= 1) begin
				e = window_edge(left, mid, cur, c - 1, flush);
				if (pin_armed && produced == 0) e = pin_val;
				expected_edges.push_back(e);
				produced++;
			end
			if (c + 1 == width_cfg) begin
				e = window_edge((c >= 1) ? mid : blank, cur, blank, c, flush);
				if (pin_armed && produced == 0) e = pin_val;
				expected_edges.push_back(e);
				produced++;
			end
		end
		pin_armed = 1'b0;
		win[3] = win[0]; win[4] = win[1]; win[5] = win[2];
		win[0] = cur[0]; win[1] = cur[1]; win[2] = cur[2];
		prev_row2[c] = prev_row[c];
		prev_row[c] = px;
		c++;
		if (c >= width_cfg) begin
			c = 0;
			r++;
			if (r > height_cfg) r = 0;
		end
		col_cnt = c;
		row_cnt = r;
	endfunction

	always @(posedge clk) begin
		edge_res_t got, want;
		if (arst_n) begin
			if (mag_ch.valid && mag_ch.ready) begin
				got = mag_ch.data;
				if (expected_edges.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10) $display("unexpected result %h", got);
				end else begin
					want = expected_edges.pop_front();
					if (got !== want) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("mismatch: exp r%0d g%0d b%0d re%b fe%b got r%0d g%0d b%0d re%b fe%b",
								want.mag_r, want.mag_g, want.mag_b, want.row_end, want.frame_end,
								got.mag_r, got.mag_g, got.mag_b, got.row_end, got.frame_end);
					end
				end
			end
			if (pix_ch.valid && pix_ch.ready) predict_edges(pix_ch.data);
		end
	end

	// receiver stall pattern, chosen from bits 10:8 of a falling-edge tick count
	always @(negedge clk) begin
		int unsigned tick;
		tick++;
		case (tick[10:8] % 4)
			0: mag_ch.ready <= 1'b1;
			1: mag_ch.ready <= $urandom_range(0, 1);
			2: mag_ch.ready <= (tick[1:0] == 2'd0);
			default: mag_ch.ready <= ($urandom_range(0, 9) != 0);
		endcase
	end

	task automatic write_reg(input logic [0:0] idx, input int unsigned val);
		pix_ch.valid <= 1'b0;
		while (expected_edges.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
		if (idx == REG_WIDTH) begin
			width_cfg = val & 11'h7FF;
			if (width_cfg == 0) width_cfg = 1;
			if (width_cfg > MAX_WIDTH) width_cfg = MAX_WIDTH;
		end else begin
			height_cfg = val & 13'h1FFF;
			if (height_cfg == 0) height_cfg = 1;
		end
		win = '{default: '0};
		col_cnt = 0;
		row_cnt = 0;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_pixel(input pixel_t px);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) begin
				pix_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		pix_ch.valid <= 1'b1;
		pix_ch.data <= px;
		do @(posedge clk); while (!pix_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p = $urandom;
		for (int k = 0; k < 3; k++)
			case ($urandom_range(0, 7))
				0: p[k*8 +: 8] = 8'h00;
				1: p[k*8 +: 8] = 8'hFF;
				default: ;
			endcase
		return p;
	endfunction

	dir_row_t dir_rows [] = '{
		'{ROW_SET_W, 1, 24'h0, 0, '0},
		'{ROW_SET_H, 1, 24'h0, 0, '0},
		'{ROW_PIX, 0, 24'hFFFFFF, 0, '0},
		'{ROW_PIX, 0, 24'h123456, 1, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1}},
		'{ROW_SET_H, 2, 24'h0, 0, '0},
		'{ROW_PIX, 0, 24'hFFFFFF, 0, '0},
		'{ROW_PIX, 0, 24'hFFFFFF, 1, '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0}},
		'{ROW_PIX, 0, 24'hFFFFFF, 0, '0},
		'{ROW_SET_W, 0, 24'h0, 0, '0},
		'{ROW_SET_H, 0, 24'h0, 0, '0},
		'{ROW_PIX, 0, 24'hAA55AA, 0, '0},
		'{ROW_PIX, 0, 24'h000000, 0, '0},
		'{ROW_SET_W, 3, 24'h0, 0, '0},
		'{ROW_SET_H, 2, 24'h0, 0, '0},
		'{ROW_PIX, 0, 24'hFF0000, 0, '0},
		'{ROW_PIX, 0, 24'h00FF00, 0, '0},
		'{ROW_PIX, 0, 24'h0000FF, 0, '0},
		'{ROW_PIX, 0, 24'h55AA55, 0, '0},
		'{ROW_PIX, 0, 24'hFFFFFF, 0, '0},
		'{ROW_PIX, 0, 24'h000000, 0, '0},
		'{ROW_PIX, 0, 24'h000000, 0, '0},
		'{ROW_PIX, 0, 24'hFFFFFF, 0, '0},
		'{ROW_PIX, 0, 24'h000000, 0, '0}
	};

	initial begin
		int unsigned w, h, n, kind;
		bit big_done, drained;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.data = '0;
		mag_ch.ready = 1'b0;
		fail_cnt = 0;
		items_sent = 0;
		pin_armed = 1'b0;
		burst_left = 0;
		big_done = 0;
		drained = 0;
		width_cfg = MAX_WIDTH;
		height_cfg = 1024;
		col_cnt = 0;
		row_cnt = 0;
		win = '{default: '0};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_SET_W: write_reg(REG_WIDTH, dir_rows[i].value);
				ROW_SET_H: write_reg(REG_HEIGHT, dir_rows[i].value);
				default: begin
					pin_armed = dir_rows[i].pinned;
					pin_val = dir_rows[i].pin;
					send_pixel(dir_rows[i].px);
				end
			endcase
		end

		while (items_sent < 1850) begin
			kind = $urandom_range(0, 19);
			if (!big_done && (kind == 0 || items_sent >= 700)) begin
				// widest rows: one full row then part of the next, then abandon
				big_done = 1;
				write_reg(REG_WIDTH, 2047);
				write_reg(REG_HEIGHT, $urandom_range(2, 8191));
				repeat (MAX_WIDTH + 24) send_pixel(rand_pixel());
			end else if (kind == 1) begin
				write_reg(REG_WIDTH, $urandom_range(1, 4));
				write_reg(REG_HEIGHT, ($urandom_range(0, 3) == 0) ? 13'h1FFF : $urandom);
				repeat ($urandom_range(5, 40)) send_pixel(rand_pixel());
			end else begin
				w = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 8);
				h = $urandom_range(1, 6);
				write_reg(REG_WIDTH, w);
				write_reg(REG_HEIGHT, h);
				n = w * (h + 1);
				for (int k = 0; k < n; k++) begin
					if (!drained && k == n / 2) begin
						drained = 1;
						pix_ch.valid <= 1'b0;
						while (expected_edges.size() != 0) @(negedge clk);
					end
					send_pixel(rand_pixel());
				end
			end
		end

		pix_ch.valid <= 1'b0;
		while (expected_edges.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		if (fail_cnt == 0 && expected_edges.size() == 0) begin
			$display("sobel_edge_magnitude_rgb verification clean");
		end else begin
			$display("sobel_edge_magnitude_rgb verification failed");
		end
		$finish;
	end
endmodule
